/* design/svfbm_pkg.sv */
package svfbm_pkg;

   // Filter bank shape
   localparam int STAGES      = 3;
   localparam int SAMPLE_BITS = 24;
   localparam int CHANNELS    = 2;
   localparam int COEF_SETS   = 3;

   // Field widths
   localparam int COEF_W = 20;
   localparam int DAMP_W = 17;
   localparam int GAIN_W = 16;
   localparam int OUT_W  = 32;
   localparam int ST_W   = 40;

   // Datapath widths
   localparam int MA_W    = COEF_W + 1;
   localparam int BLO_W   = ST_W / 2;
   localparam int BHI_W   = ST_W - BLO_W;
   localparam int PROD_W  = MA_W + ST_W + 1;
   localparam int NUM_W   = 47;
   localparam int DEN_W   = 26;
   localparam int FRAC_W  = 16;
   localparam int DVD_W   = NUM_W - 1 + FRAC_W;
   localparam int DIV_ITER = DVD_W / 2;
   localparam int DIV_CNT_W = $clog2(DIV_ITER);
   localparam int SUM_W   = ST_W + 4;
   localparam int STG_W   = (STAGES > 1) ? $clog2(STAGES) : 1;
   localparam int CSEL_W  = 2;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;
   localparam int ONE_Q16 = 65536;

   localparam logic signed [ST_W-1:0] ST_MAX = {1'b0, {(ST_W-1){1'b1}}};
   localparam logic signed [ST_W-1:0] ST_MIN = {1'b1, {(ST_W-1){1'b0}}};

   // Register indexes
   localparam logic [2:0] REG_LEFT_A  = 3'd0;
   localparam logic [2:0] REG_LEFT_B  = 3'd1;
   localparam logic [2:0] REG_LEFT_C  = 3'd2;
   localparam logic [2:0] REG_RIGHT_A = 3'd3;
   localparam logic [2:0] REG_RIGHT_B = 3'd4;
   localparam logic [2:0] REG_RIGHT_C = 3'd5;
   localparam logic [2:0] REG_DAMPING = 3'd6;
   localparam logic [2:0] REG_GAIN    = 3'd7;

   // Datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_X    = 4'd0;
   localparam logic [OP_W-1:0] OP_LOAD = 4'd1;
   localparam logic [OP_W-1:0] OP_DEN1 = 4'd2;
   localparam logic [OP_W-1:0] OP_DEN2 = 4'd3;
   localparam logic [OP_W-1:0] OP_NUM  = 4'd4;
   localparam logic [OP_W-1:0] OP_HP   = 4'd5;
   localparam logic [OP_W-1:0] OP_BP   = 4'd6;
   localparam logic [OP_W-1:0] OP_S1   = 4'd7;
   localparam logic [OP_W-1:0] OP_LP   = 4'd8;
   localparam logic [OP_W-1:0] OP_S2   = 4'd9;
   localparam logic [OP_W-1:0] OP_OUT  = 4'd10;

   typedef struct packed {
      logic [CHANNELS-1:0][COEF_SETS-1:0][COEF_W-1:0] coef;
      logic [DAMP_W-1:0]                              damping;
      logic [GAIN_W-1:0]                              gain;
   } cfg_type;

   typedef struct packed {
      logic              go;
      logic              capture;
      logic [OP_W-1:0]   op;
      logic              chan;
      logic [STG_W-1:0]  stage;
      logic [CSEL_W-1:0] csel;
   } cmd_type;

   typedef struct packed {
      logic done;
      logic out_busy;
   } sts_type;

endpackage

/* design/svfbm_mul.sv */
module svfbm_mul (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                go,
   input  logic [svfbm_pkg::MA_W-1:0]          a,
   input  logic signed [svfbm_pkg::ST_W-1:0]   b,
   output logic                                done,
   output logic signed [svfbm_pkg::PROD_W-1:0] prod
);

   localparam logic [1:0] M_IDLE = 2'd0;
   localparam logic [1:0] M_PART = 2'd1;
   localparam logic [1:0] M_SUM  = 2'd2;

   logic [1:0]                         step_ff, step_in;
   logic                               done_ff, done_in;
   logic [svfbm_pkg::MA_W-1:0]         a_ff, a_in;
   logic signed [svfbm_pkg::ST_W-1:0]  b_ff, b_in;
   logic [svfbm_pkg::MA_W+svfbm_pkg::BLO_W-1:0]          lo_ff, lo_in;
   logic signed [svfbm_pkg::MA_W+svfbm_pkg::BHI_W:0]     hi_ff, hi_in;
   logic signed [svfbm_pkg::PROD_W-1:0] prod_ff, prod_in;

   logic [svfbm_pkg::MA_W+svfbm_pkg::BLO_W-1:0]      lo_part;
   logic signed [svfbm_pkg::MA_W+svfbm_pkg::BHI_W:0] hi_part;

   // Two partial products: unsigned low half, signed high half
   assign lo_part = a_ff * b_ff[svfbm_pkg::BLO_W-1:0];
   assign hi_part = $signed({1'b0, a_ff}) * $signed(b_ff[svfbm_pkg::ST_W-1:svfbm_pkg::BLO_W]);

   always_comb begin
      step_in = step_ff;
      done_in = 1'b0;
      a_in    = a_ff;
      b_in    = b_ff;
      lo_in   = lo_ff;
      hi_in   = hi_ff;
      prod_in = prod_ff;
      case (step_ff)
         M_IDLE: begin
            if (go) begin
               a_in    = a;
               b_in    = b;
               step_in = M_PART;
            end
         end
         M_PART: begin
            lo_in   = lo_part;
            hi_in   = hi_part;
            step_in = M_SUM;
         end
         M_SUM: begin
            // Combine the halves
            prod_in = $signed({{(svfbm_pkg::PROD_W-svfbm_pkg::MA_W-svfbm_pkg::BLO_W){1'b0}},
                               lo_ff})
                      + (svfbm_pkg::PROD_W'(hi_ff) <<< svfbm_pkg::BLO_W);
            done_in = 1'b1;
            step_in = M_IDLE;
         end
         default: step_in = M_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= M_IDLE;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         done_ff <= done_in;
      end
      a_ff    <= a_in;
      b_ff    <= b_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      prod_ff <= prod_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule

/* design/svfbm_div.sv */
module svfbm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               go,
   input  logic signed [svfbm_pkg::NUM_W-1:0] num,
   input  logic [svfbm_pkg::DEN_W-1:0]        den,
   output logic                               done,
   output logic signed [svfbm_pkg::ST_W-1:0]  quo
);

   localparam logic [1:0] D_IDLE = 2'd0;
   localparam logic [1:0] D_RUN  = 2'd1;
   localparam logic [1:0] D_FIN  = 2'd2;

   logic [1:0]                          state_ff, state_in;
   logic                                done_ff, done_in;
   logic                                neg_ff, neg_in;
   logic [svfbm_pkg::DVD_W-1:0]         dvd_ff, dvd_in;
   logic [svfbm_pkg::DVD_W-1:0]         q_ff, q_in;
   logic [svfbm_pkg::DEN_W-1:0]         rem_ff, rem_in;
   logic [svfbm_pkg::DEN_W-1:0]         den_ff, den_in;
   logic [svfbm_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [svfbm_pkg::ST_W-1:0]   quo_ff, quo_in;

   logic signed [svfbm_pkg::NUM_W-1:0]  mag;
   logic [svfbm_pkg::DEN_W:0]           t1, t2;
   logic [svfbm_pkg::DEN_W-1:0]         r1, r2;
   logic                                b1, b2;
   logic                                ovf;

   assign mag = num[svfbm_pkg::NUM_W-1] ? -num : num;

   // Two restoring steps a cycle
   always_comb begin
      t1 = {rem_ff, dvd_ff[svfbm_pkg::DVD_W-1]};
      b1 = (t1 >= {1'b0, den_ff});
      r1 = b1 ? svfbm_pkg::DEN_W'(t1 - {1'b0, den_ff}) : t1[svfbm_pkg::DEN_W-1:0];
      t2 = {r1, dvd_ff[svfbm_pkg::DVD_W-2]};
      b2 = (t2 >= {1'b0, den_ff});
      r2 = b2 ? svfbm_pkg::DEN_W'(t2 - {1'b0, den_ff}) : t2[svfbm_pkg::DEN_W-1:0];
   end

   assign ovf = |q_ff[svfbm_pkg::DVD_W-1:svfbm_pkg::ST_W-1];

   always_comb begin
      state_in = state_ff;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      dvd_in   = dvd_ff;
      q_in     = q_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      cnt_in   = cnt_ff;
      quo_in   = quo_ff;
      case (state_ff)
         D_IDLE: begin
            if (go) begin
               neg_in   = num[svfbm_pkg::NUM_W-1];
               dvd_in   = {mag[svfbm_pkg::NUM_W-2:0], {svfbm_pkg::FRAC_W{1'b0}}};
               q_in     = '0;
               rem_in   = '0;
               den_in   = den;
               cnt_in   = svfbm_pkg::DIV_CNT_W'(svfbm_pkg::DIV_ITER - 1);
               state_in = D_RUN;
            end
         end
         D_RUN: begin
            rem_in = r2;
            dvd_in = dvd_ff << 2;
            q_in   = {q_ff[svfbm_pkg::DVD_W-3:0], b1, b2};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            // Apply sign and clamp to the state range
            if (neg_ff) begin
               quo_in = ovf ? svfbm_pkg::ST_MIN : -$signed(q_ff[svfbm_pkg::ST_W-1:0]);
            end else begin
               quo_in = ovf ? svfbm_pkg::ST_MAX : $signed(q_ff[svfbm_pkg::ST_W-1:0]);
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      neg_ff <= neg_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

/* design/svfbm_dp.sv */
module svfbm_dp (
   input  logic                                       clock,
   input  logic                                       reset,
   input  svfbm_pkg::cfg_type                         cfg,
   input  svfbm_pkg::cmd_type                         cmd,
   output svfbm_pkg::sts_type                         sts,
   input  logic signed [svfbm_pkg::SAMPLE_BITS-1:0]   left_sample,
   input  logic signed [svfbm_pkg::SAMPLE_BITS-1:0]   right_sample,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [svfbm_pkg::OUT_W-1:0]         low_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]         low_right,
   output logic signed [svfbm_pkg::OUT_W-1:0]         high_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]         high_right,
   output logic signed [svfbm_pkg::OUT_W-1:0]         band_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]         band_right
);

   localparam int CH = svfbm_pkg::CHANNELS;
   localparam int NS = svfbm_pkg::STAGES;

   function automatic logic signed [svfbm_pkg::ST_W-1:0] sat_st(
      input logic signed [svfbm_pkg::NUM_W-1:0] v);
      logic signed [svfbm_pkg::ST_W-1:0] r;
      if (v > svfbm_pkg::NUM_W'(svfbm_pkg::ST_MAX)) begin
         r = svfbm_pkg::ST_MAX;
      end else if (v < svfbm_pkg::NUM_W'(svfbm_pkg::ST_MIN)) begin
         r = svfbm_pkg::ST_MIN;
      end else begin
         r = v[svfbm_pkg::ST_W-1:0];
      end
      return r;
   endfunction

   function automatic logic signed [svfbm_pkg::OUT_W-1:0] triple_sat(
      input logic signed [svfbm_pkg::SUM_W-1:0] s);
      logic signed [svfbm_pkg::SUM_W+1:0] t;
      logic signed [svfbm_pkg::OUT_W-1:0] r;
      t = (svfbm_pkg::SUM_W+2)'(s) + ((svfbm_pkg::SUM_W+2)'(s) <<< 1);
      if (t > $signed((svfbm_pkg::SUM_W+2)'({1'b0, {(svfbm_pkg::OUT_W-1){1'b1}}}))) begin
         r = {1'b0, {(svfbm_pkg::OUT_W-1){1'b1}}};
      end else if (t < -$signed((svfbm_pkg::SUM_W+2)'({1'b1,
                                                          {(svfbm_pkg::OUT_W-1){1'b0}}}))) begin
         r = {1'b1, {(svfbm_pkg::OUT_W-1){1'b0}}};
      end else begin
         r = t[svfbm_pkg::OUT_W-1:0];
      end
      return r;
   endfunction

   // Filter state
   logic signed [svfbm_pkg::ST_W-1:0] s1_mem_ff [CH][NS];
   logic signed [svfbm_pkg::ST_W-1:0] s1_mem_in [CH][NS];
   logic signed [svfbm_pkg::ST_W-1:0] s2_mem_ff [CH][NS];
   logic signed [svfbm_pkg::ST_W-1:0] s2_mem_in [CH][NS];

   // Working registers
   logic signed [svfbm_pkg::SAMPLE_BITS-1:0] smp_ff [CH];
   logic signed [svfbm_pkg::SAMPLE_BITS-1:0] smp_in [CH];
   logic signed [svfbm_pkg::ST_W-1:0]  x_ff, x_in;
   logic [svfbm_pkg::COEF_W-1:0]       g_ff, g_in;
   logic signed [svfbm_pkg::ST_W-1:0]  s1_ff, s1_in, s2_ff, s2_in;
   logic [svfbm_pkg::DEN_W-1:0]        den_ff, den_in;
   logic signed [svfbm_pkg::NUM_W-1:0] num_ff, num_in;
   logic signed [svfbm_pkg::ST_W-1:0]  hp_ff, hp_in, bp_ff, bp_in, lp_ff, lp_in;
   logic signed [svfbm_pkg::NUM_W-1:0] ghp_ff, ghp_in, gbp_ff, gbp_in;
   logic signed [svfbm_pkg::SUM_W-1:0] sum_lp_ff [CH];
   logic signed [svfbm_pkg::SUM_W-1:0] sum_lp_in [CH];
   logic signed [svfbm_pkg::SUM_W-1:0] sum_hp_ff [CH];
   logic signed [svfbm_pkg::SUM_W-1:0] sum_hp_in [CH];
   logic signed [svfbm_pkg::SUM_W-1:0] sum_bp_ff [CH];
   logic signed [svfbm_pkg::SUM_W-1:0] sum_bp_in [CH];
   logic                               sdone_ff, sdone_in;

   // Result register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic signed [svfbm_pkg::OUT_W-1:0] low_left_ff, low_left_in, low_right_ff, low_right_in;
   logic signed [svfbm_pkg::OUT_W-1:0] high_left_ff, high_left_in;
   logic signed [svfbm_pkg::OUT_W-1:0] high_right_ff, high_right_in;
   logic signed [svfbm_pkg::OUT_W-1:0] band_left_ff, band_left_in;
   logic signed [svfbm_pkg::OUT_W-1:0] band_right_ff, band_right_in;

   // Shared units
   logic                                mul_go, mul_done, div_go, div_done;
   logic [svfbm_pkg::MA_W-1:0]          mul_a;
   logic signed [svfbm_pkg::ST_W-1:0]   mul_b;
   logic signed [svfbm_pkg::PROD_W-1:0] mul_p, mul_p16;
   logic signed [svfbm_pkg::ST_W-1:0]   div_q;
   logic signed [svfbm_pkg::ST_W-1:0]   g_ext;
   logic                                out_busy;

   assign g_ext    = $signed(svfbm_pkg::ST_W'(g_ff));
   assign mul_p16  = mul_p >>> svfbm_pkg::FRAC_W;
   assign out_busy = rsp_valid_ff && rsp_stall;

   // Select multiplier operands by operation
   always_comb begin
      mul_go = 1'b0;
      mul_a  = svfbm_pkg::MA_W'(g_ff);
      mul_b  = g_ext;
      case (cmd.op)
         svfbm_pkg::OP_X: begin
            mul_go = cmd.go;
            mul_a  = svfbm_pkg::MA_W'(cfg.gain);
            mul_b  = svfbm_pkg::ST_W'(smp_ff[cmd.chan]);
         end
         svfbm_pkg::OP_DEN1: begin
            mul_go = cmd.go;
            mul_a  = svfbm_pkg::MA_W'(cfg.damping);
         end
         svfbm_pkg::OP_DEN2: begin
            mul_go = cmd.go;
         end
         svfbm_pkg::OP_NUM: begin
            mul_go = cmd.go;
            mul_a  = svfbm_pkg::MA_W'(cfg.damping) + svfbm_pkg::MA_W'(g_ff);
            mul_b  = s1_ff;
         end
         svfbm_pkg::OP_BP: begin
            mul_go = cmd.go;
            mul_b  = hp_ff;
         end
         svfbm_pkg::OP_LP: begin
            mul_go = cmd.go;
            mul_b  = bp_ff;
         end
         default: mul_go = 1'b0;
      endcase
   end

   assign div_go = cmd.go && (cmd.op == svfbm_pkg::OP_HP);

   svfbm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .go    (mul_go),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   svfbm_div u_div (
      .clock (clock),
      .reset (reset),
      .go    (div_go),
      .num   (num_ff),
      .den   (den_ff),
      .done  (div_done),
      .quo   (div_q)
   );

   always_comb begin
      s1_mem_in     = s1_mem_ff;
      s2_mem_in     = s2_mem_ff;
      smp_in        = smp_ff;
      x_in          = x_ff;
      g_in          = g_ff;
      s1_in         = s1_ff;
      s2_in         = s2_ff;
      den_in        = den_ff;
      num_in        = num_ff;
      hp_in         = hp_ff;
      bp_in         = bp_ff;
      lp_in         = lp_ff;
      ghp_in        = ghp_ff;
      gbp_in        = gbp_ff;
      sum_lp_in     = sum_lp_ff;
      sum_hp_in     = sum_hp_ff;
      sum_bp_in     = sum_bp_ff;
      sdone_in      = 1'b0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      low_left_in   = low_left_ff;
      low_right_in  = low_right_ff;
      high_left_in  = high_left_ff;
      high_right_in = high_right_ff;
      band_left_in  = band_left_ff;
      band_right_in = band_right_ff;

      // Latch the incoming beat
      if (cmd.capture) begin
         smp_in[0] = left_sample;
         smp_in[1] = right_sample;
      end

      // Operations done without the shared units
      if (cmd.go) begin
         case (cmd.op)
            svfbm_pkg::OP_LOAD: begin
               g_in     = cfg.coef[cmd.chan][cmd.csel];
               s1_in    = s1_mem_ff[cmd.chan][cmd.stage];
               s2_in    = s2_mem_ff[cmd.chan][cmd.stage];
               sdone_in = 1'b1;
            end
            svfbm_pkg::OP_S1: begin
               s1_mem_in[cmd.chan][cmd.stage] = sat_st(ghp_ff + svfbm_pkg::NUM_W'(bp_ff));
               sum_bp_in[cmd.chan] = sum_bp_ff[cmd.chan] + svfbm_pkg::SUM_W'(bp_ff);
               sdone_in = 1'b1;
            end
            svfbm_pkg::OP_S2: begin
               s2_mem_in[cmd.chan][cmd.stage] = sat_st(gbp_ff + svfbm_pkg::NUM_W'(lp_ff));
               sum_lp_in[cmd.chan] = sum_lp_ff[cmd.chan] + svfbm_pkg::SUM_W'(lp_ff);
               sdone_in = 1'b1;
            end
            svfbm_pkg::OP_OUT: begin
               low_left_in   = triple_sat(sum_lp_ff[0]);
               low_right_in  = triple_sat(sum_lp_ff[1]);
               high_left_in  = triple_sat(sum_hp_ff[0]);
               high_right_in = triple_sat(sum_hp_ff[1]);
               band_left_in  = triple_sat(sum_bp_ff[0]);
               band_right_in = triple_sat(sum_bp_ff[1]);
               rsp_valid_in  = 1'b1;
               sdone_in      = 1'b1;
            end
            default: sdone_in = 1'b0;
         endcase
      end

      // Retire multiplier results
      if (mul_done) begin
         case (cmd.op)
            svfbm_pkg::OP_X: begin
               x_in = svfbm_pkg::ST_W'(mul_p16);
               sum_lp_in[cmd.chan] = '0;
               sum_hp_in[cmd.chan] = '0;
               sum_bp_in[cmd.chan] = '0;
            end
            svfbm_pkg::OP_DEN1: begin
               den_in = svfbm_pkg::DEN_W'(svfbm_pkg::ONE_Q16) + svfbm_pkg::DEN_W'(mul_p16);
            end
            svfbm_pkg::OP_DEN2: begin
               den_in = den_ff + svfbm_pkg::DEN_W'(mul_p16);
            end
            svfbm_pkg::OP_NUM: begin
               num_in = svfbm_pkg::NUM_W'(x_ff) - svfbm_pkg::NUM_W'(mul_p16)
                        - svfbm_pkg::NUM_W'(s2_ff);
            end
            svfbm_pkg::OP_BP: begin
               ghp_in = svfbm_pkg::NUM_W'(mul_p16);
               bp_in  = sat_st(svfbm_pkg::NUM_W'(mul_p16) + svfbm_pkg::NUM_W'(s1_ff));
            end
            svfbm_pkg::OP_LP: begin
               gbp_in = svfbm_pkg::NUM_W'(mul_p16);
               lp_in  = sat_st(svfbm_pkg::NUM_W'(mul_p16) + svfbm_pkg::NUM_W'(s2_ff));
            end
            default: x_in = x_ff;
         endcase
      end

      // Retire divider result
      if (div_done) begin
         hp_in = div_q;
         sum_hp_in[cmd.chan] = sum_hp_ff[cmd.chan] + svfbm_pkg::SUM_W'(div_q);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sdone_ff     <= 1'b0;
         for (int c = 0; c < CH; c++) begin
            for (int k = 0; k < NS; k++) begin
               s1_mem_ff[c][k] <= '0;
               s2_mem_ff[c][k] <= '0;
            end
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sdone_ff     <= sdone_in;
         s1_mem_ff    <= s1_mem_in;
         s2_mem_ff    <= s2_mem_in;
      end
      smp_ff        <= smp_in;
      x_ff          <= x_in;
      g_ff          <= g_in;
      s1_ff         <= s1_in;
      s2_ff         <= s2_in;
      den_ff        <= den_in;
      num_ff        <= num_in;
      hp_ff         <= hp_in;
      bp_ff         <= bp_in;
      lp_ff         <= lp_in;
      ghp_ff        <= ghp_in;
      gbp_ff        <= gbp_in;
      sum_lp_ff     <= sum_lp_in;
      sum_hp_ff     <= sum_hp_in;
      sum_bp_ff     <= sum_bp_in;
      low_left_ff   <= low_left_in;
      low_right_ff  <= low_right_in;
      high_left_ff  <= high_left_in;
      high_right_ff <= high_right_in;
      band_left_ff  <= band_left_in;
      band_right_ff <= band_right_in;
   end

   assign sts.done     = sdone_ff || mul_done || div_done;
   assign sts.out_busy = out_busy;

   assign rsp_valid  = rsp_valid_ff;
   assign low_left   = low_left_ff;
   assign low_right  = low_right_ff;
   assign high_left  = high_left_ff;
   assign high_right = high_right_ff;
   assign band_left  = band_left_ff;
   assign band_right = band_right_ff;

   // Only one shared unit finishes at a time
   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done))
      else $error("multiplier and divider finished together");

   // Never overwrite a result beat that is still held
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.go && (cmd.op == svfbm_pkg::OP_OUT)) |-> !out_busy)
      else $error("result issued while previous beat stalled");

   // Denominator is at least one when the divide starts
   a_den_floor: assert property (@(posedge clock) disable iff (reset)
      div_go |-> (den_ff >= svfbm_pkg::DEN_W'(svfbm_pkg::ONE_Q16)))
      else $error("divide started with denominator below one");

endmodule

/* design/svfbm_ctrl.sv */
module svfbm_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output svfbm_pkg::cmd_type cmd,
   input  svfbm_pkg::sts_type sts
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic                             state_ff, state_in;
   logic                             pend_ff, pend_in;
   logic [svfbm_pkg::OP_W-1:0]       op_ff, op_in;
   logic                             chan_ff, chan_in;
   logic [svfbm_pkg::STG_W-1:0]      stage_ff, stage_in;
   logic [svfbm_pkg::CSEL_W-1:0]     csel_ff, csel_in;
   logic                             go;
   logic                             capture;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      op_in    = op_ff;
      chan_in  = chan_ff;
      stage_in = stage_ff;
      csel_in  = csel_ff;
      go       = 1'b0;
      capture  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // Take a beat and start at the left channel
            if (req_valid) begin
               capture  = 1'b1;
               state_in = S_RUN;
               pend_in  = 1'b0;
               op_in    = svfbm_pkg::OP_X;
               chan_in  = 1'b0;
               stage_in = '0;
               csel_in  = '0;
            end
         end
         S_RUN: begin
            if (!pend_ff) begin
               // Issue, holding the result step while the output is stalled
               if ((op_ff != svfbm_pkg::OP_OUT) || !sts.out_busy) begin
                  go      = 1'b1;
                  pend_in = 1'b1;
               end
            end else if (sts.done) begin
               pend_in = 1'b0;
               case (op_ff)
                  svfbm_pkg::OP_X:    op_in = svfbm_pkg::OP_LOAD;
                  svfbm_pkg::OP_LOAD: op_in = svfbm_pkg::OP_DEN1;
                  svfbm_pkg::OP_DEN1: op_in = svfbm_pkg::OP_DEN2;
                  svfbm_pkg::OP_DEN2: op_in = svfbm_pkg::OP_NUM;
                  svfbm_pkg::OP_NUM:  op_in = svfbm_pkg::OP_HP;
                  svfbm_pkg::OP_HP:   op_in = svfbm_pkg::OP_BP;
                  svfbm_pkg::OP_BP:   op_in = svfbm_pkg::OP_S1;
                  svfbm_pkg::OP_S1:   op_in = svfbm_pkg::OP_LP;
                  svfbm_pkg::OP_LP:   op_in = svfbm_pkg::OP_S2;
                  svfbm_pkg::OP_S2: begin
                     if (stage_ff == svfbm_pkg::STG_W'(svfbm_pkg::STAGES - 1)) begin
                        stage_in = '0;
                        csel_in  = '0;
                        if (chan_ff) begin
                           op_in = svfbm_pkg::OP_OUT;
                        end else begin
                           chan_in = 1'b1;
                           op_in   = svfbm_pkg::OP_X;
                        end
                     end else begin
                        // Advance stage; coefficient set wraps every three stages
                        stage_in = stage_ff + 1'b1;
                        csel_in  = (csel_ff == svfbm_pkg::CSEL_W'(svfbm_pkg::COEF_SETS - 1))
                                   ? '0 : csel_ff + 1'b1;
                        op_in    = svfbm_pkg::OP_LOAD;
                     end
                  end
                  svfbm_pkg::OP_OUT:  state_in = S_IDLE;
                  default:            state_in = S_IDLE;
               endcase
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pend_ff  <= 1'b0;
         op_ff    <= svfbm_pkg::OP_X;
         chan_ff  <= 1'b0;
         stage_ff <= '0;
         csel_ff  <= '0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         op_ff    <= op_in;
         chan_ff  <= chan_in;
         stage_ff <= stage_in;
         csel_ff  <= csel_in;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign cmd.go      = go;
   assign cmd.capture = capture;
   assign cmd.op      = op_ff;
   assign cmd.chan    = chan_ff;
   assign cmd.stage   = stage_ff;
   assign cmd.csel    = csel_ff;

endmodule

/* design/stereo_svf_bank_mixer_unit.sv */
// Each stage uses the two-bit-per-cycle divide, the shared multiplier and steps
// done in the datapath itself; the result step waits while the output is stalled.
// Only one sample pair is in work at a time; a new beat is taken while the
// previous result waits on the output register.
// Reset (synchronous, active high) clears both integrators of every stage and
// loads the register reset values; the output register comes up empty.
module stereo_svf_bank_mixer_unit (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic signed [svfbm_pkg::SAMPLE_BITS-1:0]  req_left_sample,
   input  logic signed [svfbm_pkg::SAMPLE_BITS-1:0]  req_right_sample,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_low_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_low_right,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_high_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_high_right,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_band_left,
   output logic signed [svfbm_pkg::OUT_W-1:0]        rsp_band_right,
   input  logic                                      psel,
   input  logic                                      penable,
   input  logic                                      pwrite,
   input  logic [svfbm_pkg::ADDR_W-1:0]              paddr,
   input  logic [svfbm_pkg::DATA_W-1:0]              pwdata,
   output logic [svfbm_pkg::DATA_W-1:0]              prdata,
   output logic                                      pready
);

   svfbm_pkg::cfg_type cfg_ff, cfg_in;
   svfbm_pkg::cmd_type cmd;
   svfbm_pkg::sts_type sts;
   logic               wr_en;
   logic [2:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[svfbm_pkg::ADDR_W-1:2];

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            svfbm_pkg::REG_LEFT_A:  cfg_in.coef[0][0] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_LEFT_B:  cfg_in.coef[0][1] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_LEFT_C:  cfg_in.coef[0][2] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_RIGHT_A: cfg_in.coef[1][0] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_RIGHT_B: cfg_in.coef[1][1] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_RIGHT_C: cfg_in.coef[1][2] = pwdata[svfbm_pkg::COEF_W-1:0];
            svfbm_pkg::REG_DAMPING: cfg_in.damping    = pwdata[svfbm_pkg::DAMP_W-1:0];
            svfbm_pkg::REG_GAIN:    cfg_in.gain       = pwdata[svfbm_pkg::GAIN_W-1:0];
            default:                cfg_in            = cfg_ff;
         endcase
      end
   end

   // Register reads
   always_comb begin
      case (reg_idx)
         svfbm_pkg::REG_LEFT_A:  prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[0][0]);
         svfbm_pkg::REG_LEFT_B:  prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[0][1]);
         svfbm_pkg::REG_LEFT_C:  prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[0][2]);
         svfbm_pkg::REG_RIGHT_A: prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[1][0]);
         svfbm_pkg::REG_RIGHT_B: prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[1][1]);
         svfbm_pkg::REG_RIGHT_C: prdata = svfbm_pkg::DATA_W'(cfg_ff.coef[1][2]);
         svfbm_pkg::REG_DAMPING: prdata = svfbm_pkg::DATA_W'(cfg_ff.damping);
         svfbm_pkg::REG_GAIN:    prdata = svfbm_pkg::DATA_W'(cfg_ff.gain);
         default:                prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < svfbm_pkg::CHANNELS; c++) begin
            for (int k = 0; k < svfbm_pkg::COEF_SETS; k++) begin
               cfg_ff.coef[c][k] <= svfbm_pkg::COEF_W'(4293);
            end
         end
         cfg_ff.damping <= svfbm_pkg::DAMP_W'(65536);
         cfg_ff.gain    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   svfbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   svfbm_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .sts          (sts),
      .left_sample  (req_left_sample),
      .right_sample (req_right_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .low_left     (rsp_low_left),
      .low_right    (rsp_low_right),
      .high_left    (rsp_high_left),
      .high_right   (rsp_high_right),
      .band_left    (rsp_band_left),
      .band_right   (rsp_band_right)
   );

endmodule

/* sim/tb_stereo_svf_bank_mixer_unit.sv */
module tb_stereo_svf_bank_mixer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic signed [svfbm_pkg::SAMPLE_BITS-1:0] left;
      logic signed [svfbm_pkg::SAMPLE_BITS-1:0] right;
      bit                                       hold;
   } pair_type;

   // low_left, low_right, high_left, high_right, band_left, band_right
   typedef logic [5:0][svfbm_pkg::OUT_W-1:0] mix_type;

   localparam longint MAX40 = 64'sd549755813887;
   localparam longint MIN40 = -64'sd549755813888;
   localparam int     WATCH_LIMIT = 20000;
   localparam int     SETTLE = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [svfbm_pkg::SAMPLE_BITS-1:0] req_left_sample = '0;
   logic signed [svfbm_pkg::SAMPLE_BITS-1:0] req_right_sample = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [svfbm_pkg::OUT_W-1:0] rsp_low_left, rsp_low_right, rsp_high_left;
   logic signed [svfbm_pkg::OUT_W-1:0] rsp_high_right, rsp_band_left, rsp_band_right;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [svfbm_pkg::ADDR_W-1:0] paddr = '0;
   logic [svfbm_pkg::DATA_W-1:0] pwdata = '0;
   logic [svfbm_pkg::DATA_W-1:0] prdata;
   logic pready;

   stereo_svf_bank_mixer_unit u_top (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow of the filter registers and integrators
   longint coef_sh [2][3];
   longint damp_sh;
   longint gain_sh;
   longint integ1 [2*svfbm_pkg::STAGES];
   longint integ2 [2*svfbm_pkg::STAGES];

   pair_type pending[$];
   mix_type  mix_expected[$];
   int    pairs_sent = 0;
   int    mixes_seen = 0;
   int    mismatches = 0;
   int    quiet_cycles = 0;
   int    send_idle_pct = 0;
   int    recv_stall_pct = 0;

   function automatic longint clamp40(longint v);
      if (v > MAX40) return MAX40;
      if (v < MIN40) return MIN40;
      return v;
   endfunction

   function automatic logic [svfbm_pkg::OUT_W-1:0] clamp32(longint v);
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      return v[svfbm_pkg::OUT_W-1:0];
   endfunction

   // run one stereo pair through the filter bank and advance the integrators
   function automatic mix_type filter_pair(logic signed [svfbm_pkg::SAMPLE_BITS-1:0] l,
                                           logic signed [svfbm_pkg::SAMPLE_BITS-1:0] r);
      longint sum_lp [2];
      longint sum_hp [2];
      longint sum_bp [2];
      longint x, g, s1, s2, den, num, hp, ghp, bp, gbp, lp;
      int idx;
      mix_type m;
      for (int c = 0; c < 2; c++) begin
         x = (c == 0) ? longint'(l) : longint'(r);
         x = (x * gain_sh) >>> 16;
         sum_lp[c] = 0; sum_hp[c] = 0; sum_bp[c] = 0;
         for (int k = 0; k < svfbm_pkg::STAGES; k++) begin
            idx = c * svfbm_pkg::STAGES + k;
            g   = coef_sh[c][k % 3];
            s1  = integ1[idx];
            s2  = integ2[idx];
            den = 65536 + ((damp_sh * g) >>> 16) + ((g * g) >>> 16);
            num = x - (((damp_sh + g) * s1) >>> 16) - s2;
            hp  = clamp40((num * 65536) / den);
            ghp = (g * hp) >>> 16;
            bp  = clamp40(ghp + s1);
            gbp = (g * bp) >>> 16;
            lp  = clamp40(gbp + s2);
            integ1[idx] = clamp40(ghp + bp);
            integ2[idx] = clamp40(gbp + lp);
            sum_lp[c] += lp;
            sum_hp[c] += hp;
            sum_bp[c] += bp;
         end
      end
      m[0] = clamp32(3 * sum_lp[0]);
      m[1] = clamp32(3 * sum_lp[1]);
      m[2] = clamp32(3 * sum_hp[0]);
      m[3] = clamp32(3 * sum_hp[1]);
      m[4] = clamp32(3 * sum_bp[0]);
      m[5] = clamp32(3 * sum_bp[1]);
      return m;
   endfunction

   // driver: hold a beat until taken, then maybe fetch the next one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) pairs_sent++;
         if (!req_valid || !req_stall) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending[0].hold && (pairs_sent != mixes_seen || req_valid))) begin
               req_left_sample  <= pending[0].left;
               req_right_sample <= pending[0].right;
               req_valid        <= 1'b1;
               void'(pending.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: predict on input beats, check result beats, watch for hangs
   always @(posedge clock) begin
      mix_type got;
      mix_type want;
      bit took;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         took = 1'b0;
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         if (req_valid && !req_stall) begin
            mix_expected.push_back(filter_pair(req_left_sample, req_right_sample));
            took = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            took = 1'b1;
            mixes_seen++;
            got = {rsp_band_right, rsp_band_left, rsp_high_right, rsp_high_left,
                   rsp_low_right, rsp_low_left};
            if (mix_expected.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected result beat %h", got);
            end else begin
               want = mix_expected.pop_front();
               for (int f = 0; f < 6; f++) begin
                  if (got[f] !== want[f]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("result %0d field %0d: expected %h, got %h",
                                 mixes_seen, f, want[f], got[f]);
                  end
               end
            end
         end
         quiet_cycles = took ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCH_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // register write: setup beat, then access beat
   task automatic csr_write(logic [2:0] idx, logic [svfbm_pkg::DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= svfbm_pkg::ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         svfbm_pkg::REG_DAMPING: damp_sh = longint'(value & 32'h1FFFF);
         svfbm_pkg::REG_GAIN:    gain_sh = longint'(value & 32'hFFFF);
         default:                coef_sh[idx / 3][idx % 3] = longint'(value & 32'hFFFFF);
      endcase
   endtask

   task automatic load_bank(logic [19:0] ca, logic [19:0] cb, logic [19:0] cc,
                            logic [16:0] damp, logic [15:0] gain);
      csr_write(svfbm_pkg::REG_LEFT_A, svfbm_pkg::DATA_W'(ca));
      csr_write(svfbm_pkg::REG_LEFT_B, svfbm_pkg::DATA_W'(cb));
      csr_write(svfbm_pkg::REG_LEFT_C, svfbm_pkg::DATA_W'(cc));
      csr_write(svfbm_pkg::REG_RIGHT_A, svfbm_pkg::DATA_W'(cc));
      csr_write(svfbm_pkg::REG_RIGHT_B, svfbm_pkg::DATA_W'(ca));
      csr_write(svfbm_pkg::REG_RIGHT_C, svfbm_pkg::DATA_W'(cb));
      csr_write(svfbm_pkg::REG_DAMPING, svfbm_pkg::DATA_W'(damp));
      csr_write(svfbm_pkg::REG_GAIN, svfbm_pkg::DATA_W'(gain));
   endtask

   task automatic wait_drained();
      while (pending.size() > 0 || req_valid || pairs_sent != mixes_seen ||
             mix_expected.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic queue_pair(logic signed [svfbm_pkg::SAMPLE_BITS-1:0] l,
                             logic signed [svfbm_pkg::SAMPLE_BITS-1:0] r, bit hold);
      pair_type p;
      p.left = l; p.right = r; p.hold = hold;
      pending.push_back(p);
   endtask

   task automatic queue_random(int n);
      logic signed [svfbm_pkg::SAMPLE_BITS-1:0] l, r;
      for (int i = 0; i < n; i++) begin
         l = svfbm_pkg::SAMPLE_BITS'($urandom);
         r = svfbm_pkg::SAMPLE_BITS'($urandom);
         case ($urandom_range(9))
            0: begin l = 24'sh7FFFFF; r = 24'sh800000; end
            1, 2: begin l = l >>> 12; r = r >>> 12; end
            default: ;
         endcase
         queue_pair(l, r, i == n / 2);
      end
   endtask

   initial begin
      for (int c = 0; c < 2; c++)
         for (int k = 0; k < 3; k++) coef_sh[c][k] = 4293;
      damp_sh = 65536;
      gain_sh = 0;
      for (int k = 0; k < 2 * svfbm_pkg::STAGES; k++) begin
         integ1[k] = 0;
         integ2[k] = 0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset gain: filters see silence
      queue_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      queue_pair(24'sh123456, -24'sh1, 1'b0);
      wait_drained();

      // directed extremes at full gain, widest coefficients
      load_bank(20'hFFFFF, 20'h0, 20'd4293, 17'h1FFFF, 16'hFFFF);
      queue_pair(24'sh7FFFFF, 24'sh7FFFFF, 1'b0);
      queue_pair(24'sh800000, 24'sh800000, 1'b0);
      queue_pair(24'sh0, 24'sh0, 1'b0);
      queue_pair(-24'sh1, 24'sh1, 1'b0);
      queue_pair(24'sh7FFFFF, 24'sh800000, 1'b0);
      queue_pair(24'sh555555, 24'shAAAAAA, 1'b0);
      wait_drained();

      // zero damping
      load_bank(20'd30000, 20'd200000, 20'hFFFFF, 17'h0, 16'h8000);
      queue_pair(24'sh7FFFFF, 24'sh0, 1'b0);
      queue_pair(24'sh800000, 24'sh7FFFFF, 1'b0);
      queue_pair(24'sh0, 24'sh800000, 1'b0);
      wait_drained();

      // random phases under each idling pattern
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_bank(20'd4293, 20'd4293, 20'd4293, 17'd65536, 16'hFFFF);
            1: load_bank(20'd0, 20'd0, 20'd0, 17'd6554, 16'd1000);
            2: load_bank(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 17'h1FFFF, 16'hFFFF);
            default: load_bank(20'($urandom), 20'($urandom), 20'($urandom_range(65535)),
                               17'($urandom_range(6554, 131071)), 16'($urandom));
         endcase
         send_idle_pct  = (ph % 4 == 1) ? 79 : (ph % 4 == 3) ? 23 : 0;
         recv_stall_pct = (ph % 4 == 2) ? 79 : (ph % 4 == 3) ? 23 : 0;
         queue_random(295);
         wait_drained();
      end

      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
